// ----- src/voxel_occupancy_grid_core_assert.svh -----
// Assertion macros shared by the voxel occupancy grid checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef VOXEL_OCCUPANCY_GRID_CORE_ASSERT_SVH
`define VOXEL_OCCUPANCY_GRID_CORE_ASSERT_SVH

// Generic clocked assertion with active-low reset disable
`define VOG_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the core's own clock and reset
`define VOG_CHECK(label, prop, msg) \
    `VOG_ASSERT(label, aclk, aresetn, prop, msg)

`endif

// ----- src/voc_pkg.sv -----
// Types and constants of the voxel occupancy grid core.
// No dependencies.
package voc_pkg;

    localparam int OP_W      = 3;
    localparam int COORD_W   = 6;
    localparam int OWNER_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 3;

    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_W-1:0] OP_EXISTS     = 3'd2;
    localparam logic [OP_W-1:0] OP_EXISTS_ID  = 3'd3;
    localparam logic [OP_W-1:0] OP_NEIGHBOURS = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OCCUPIED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_NEIGHBOURS = 3'd6;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  neighbour_count;
    } voc_result_t;

endpackage

// ----- src/voc_spram.sv -----
// Single-port synchronous RAM with registered read.
// No dependencies.
module voc_spram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/voc_ctrl.sv -----
// Sequencer of the voxel occupancy grid: address generation, clearing pass,
// read-modify-write and neighbour scan. Depends on voc_pkg.
module voc_ctrl
    import voc_pkg::*;
#(
    parameter int GRID_SIDE = 64,
    parameter int ADDR_W    = 18
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_operation,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic signed [OWNER_W-1:0] s_owner_id,
    input  logic                      out_free,
    output logic                      res_valid,
    output voc_result_t               res,
    output logic [ADDR_W-1:0]         mem_addr,
    output logic                      occ_en,
    output logic                      occ_we,
    output logic                      occ_wdata,
    input  logic                      occ_rdata,
    output logic                      own_en,
    output logic                      own_we,
    output logic [OWNER_W-1:0]        own_wdata,
    input  logic [OWNER_W-1:0]        own_rdata
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int UW    = $clog2(GRID_SIDE);
    localparam int CW    = ((COORD_W > UW) ? COORD_W : UW) + 2;

    localparam logic signed [CW-1:0] HALF_C = CW'(GRID_SIDE / 2);
    localparam logic signed [CW-1:0] MAX_C  = CW'(GRID_SIDE - 1);
    localparam logic [UW-1:0]        UMAX   = UW'(GRID_SIDE - 1);
    localparam logic [ADDR_W-1:0] STEP_X    = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] STEP_Y    = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0] STEP_Z    = ADDR_W'(GRID_SIDE * GRID_SIDE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_NB    = 3'd4;

    localparam logic [2:0] NB_XP   = 3'd0;
    localparam logic [2:0] NB_XM   = 3'd1;
    localparam logic [2:0] NB_YP   = 3'd2;
    localparam logic [2:0] NB_YM   = 3'd3;
    localparam logic [2:0] NB_ZP   = 3'd4;
    localparam logic [2:0] NB_ZM   = 3'd5;
    localparam logic [2:0] NB_DONE = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [2:0]          nb_idx_reg, nb_idx_next;
    logic [COUNT_W-1:0]  nb_cnt_reg, nb_cnt_next;
    logic                nb_ok_reg, nb_ok_next;

    logic [OP_W-1:0]     op_reg;
    logic [OWNER_W-1:0]  id_reg;
    logic [UW-1:0]       ux_reg, uy_reg, uz_reg;
    logic                inside_reg;
    logic [ADDR_W-1:0]   base_reg;

    logic signed [CW-1:0] fx, fy, fz;
    logic                 in_grid;
    logic [UW-1:0]        ux_in, uy_in, uz_in;
    logic [ADDR_W-1:0]    base_in;
    logic                 accept;
    logic                 sel_ok;
    logic [ADDR_W-1:0]    sel_addr;

    assign fx = CW'(s_pos_x) + HALF_C;
    assign fy = CW'(s_pos_y) + HALF_C;
    assign fz = CW'(s_pos_z) + HALF_C;
    assign in_grid = !fx[CW-1] && (fx <= MAX_C) && !fy[CW-1] && (fy <= MAX_C)
                  && !fz[CW-1] && (fz <= MAX_C);
    assign ux_in = fx[UW-1:0];
    assign uy_in = fy[UW-1:0];
    assign uz_in = fz[UW-1:0];
    assign base_in = ADDR_W'(ux_in) + ADDR_W'(uy_in) * STEP_Y + ADDR_W'(uz_in) * STEP_Z;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        sel_ok   = 1'b0;
        sel_addr = base_reg;
        case (nb_idx_reg)
            NB_XP: begin
                sel_ok   = (ux_reg != UMAX);
                sel_addr = base_reg + STEP_X;
            end
            NB_XM: begin
                sel_ok   = (ux_reg != '0);
                sel_addr = base_reg - STEP_X;
            end
            NB_YP: begin
                sel_ok   = (uy_reg != UMAX);
                sel_addr = base_reg + STEP_Y;
            end
            NB_YM: begin
                sel_ok   = (uy_reg != '0);
                sel_addr = base_reg - STEP_Y;
            end
            NB_ZP: begin
                sel_ok   = (uz_reg != UMAX);
                sel_addr = base_reg + STEP_Z;
            end
            NB_ZM: begin
                sel_ok   = (uz_reg != '0);
                sel_addr = base_reg - STEP_Z;
            end
            default: begin
                sel_ok   = 1'b0;
                sel_addr = base_reg;
            end
        endcase
        if (!sel_ok) begin
            sel_addr = base_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        nb_idx_next = nb_idx_reg;
        nb_cnt_next = nb_cnt_reg;
        nb_ok_next  = nb_ok_reg;
        mem_addr    = base_reg;
        occ_en      = 1'b0;
        occ_we      = 1'b0;
        occ_wdata   = 1'b0;
        own_en      = 1'b0;
        own_we      = 1'b0;
        own_wdata   = id_reg;
        res_valid   = 1'b0;
        res         = '0;
        case (state_reg)
            S_CLEAR: begin
                occ_en   = 1'b1;
                occ_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (in_grid && s_operation < OP_NEIGHBOURS) begin
                        state_next = S_READ;
                    end else if (in_grid && s_operation == OP_NEIGHBOURS) begin
                        state_next  = S_NB;
                        nb_idx_next = NB_XP;
                        nb_cnt_next = '0;
                    end else begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_READ: begin
                occ_en     = 1'b1;
                own_en     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (op_reg <= OP_NEIGHBOURS && !inside_reg) begin
                    res.status = STATUS_OUTSIDE;
                end else if (inside_reg) begin
                    case (op_reg)
                        OP_INSERT: begin
                            if (occ_rdata) begin
                                res.status = STATUS_OCCUPIED;
                            end else if (out_free) begin
                                occ_en    = 1'b1;
                                occ_we    = 1'b1;
                                occ_wdata = 1'b1;
                                own_en    = 1'b1;
                                own_we    = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (!occ_rdata) begin
                                res.status = STATUS_ABSENT;
                            end else if (out_free) begin
                                occ_en = 1'b1;
                                occ_we = 1'b1;
                            end
                        end
                        OP_EXISTS: begin
                            res.found = occ_rdata;
                        end
                        OP_EXISTS_ID: begin
                            res.found = occ_rdata && (own_rdata == id_reg);
                        end
                        default: begin
                            res = '0;
                        end
                    endcase
                end
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NB: begin
                if (nb_idx_reg == NB_DONE) begin
                    res.neighbour_count = nb_cnt_reg + COUNT_W'(occ_rdata && nb_ok_reg);
                    if (out_free) begin
                        res_valid  = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    occ_en      = 1'b1;
                    mem_addr    = sel_addr;
                    nb_ok_next  = sel_ok;
                    nb_idx_next = nb_idx_reg + 3'd1;
                    if (nb_idx_reg != NB_XP) begin
                        nb_cnt_next = nb_cnt_reg + COUNT_W'(occ_rdata && nb_ok_reg);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            nb_idx_reg <= NB_XP;
            nb_cnt_reg <= '0;
            nb_ok_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            nb_idx_reg <= nb_idx_next;
            nb_cnt_reg <= nb_cnt_next;
            nb_ok_reg  <= nb_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_operation;
            id_reg     <= s_owner_id;
            ux_reg     <= ux_in;
            uy_reg     <= uy_in;
            uz_reg     <= uz_in;
            inside_reg <= in_grid;
            base_reg   <= base_in;
        end
    end

endmodule

// ----- src/voxel_occupancy_grid_core.sv -----
// Sequence: insert, remove and exists pass READ and EVAL before the result is registered;
// out-of-grid or unused codes go straight to EVAL; neighbour count steps through six reads.
// A new transaction is taken only once the last is through; neighbour count is bound by
// six reads of the single-port occupancy RAM. The next item is taken while a result waits.
// Reset: a clearing pass over all GRID_SIDE^3 cells (262144 at 64) with s_ready low.
// Top level of the voxel occupancy grid. Depends on voc_pkg, voc_ctrl, voc_spram.
module voxel_occupancy_grid_core
    import voc_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_operation,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic signed [OWNER_W-1:0] s_owner_id,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic                      m_found,
    output logic [COUNT_W-1:0]        m_neighbour_count
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                out_free;
    logic                res_valid;
    voc_result_t         res;
    logic [ADDR_W-1:0]   mem_addr;
    logic                occ_en, occ_we, occ_wdata, occ_rdata;
    logic                own_en, own_we;
    logic [OWNER_W-1:0]  own_wdata, own_rdata;

    logic                m_valid_reg, m_valid_next;
    voc_result_t         res_reg, res_next;

    voc_ctrl #(
        .GRID_SIDE (GRID_SIDE),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_owner_id  (s_owner_id),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_addr    (mem_addr),
        .occ_en      (occ_en),
        .occ_we      (occ_we),
        .occ_wdata   (occ_wdata),
        .occ_rdata   (occ_rdata),
        .own_en      (own_en),
        .own_we      (own_we),
        .own_wdata   (own_wdata),
        .own_rdata   (own_rdata)
    );

    voc_spram #(
        .WIDTH  (1),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_occ_ram (
        .aclk  (aclk),
        .en    (occ_en),
        .we    (occ_we),
        .addr  (mem_addr),
        .wdata (occ_wdata),
        .rdata (occ_rdata)
    );

    voc_spram #(
        .WIDTH  (OWNER_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_own_ram (
        .aclk  (aclk),
        .en    (own_en),
        .we    (own_we),
        .addr  (mem_addr),
        .wdata (own_wdata),
        .rdata (own_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            res_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = res_reg.status;
    assign m_found           = res_reg.found;
    assign m_neighbour_count = res_reg.neighbour_count;

endmodule

// ----- src/voc_chk.sv -----
// Port-level checker for the voxel occupancy grid core, bound to the top level.
// Depends on voc_pkg and voxel_occupancy_grid_core_assert.svh.
`include "voxel_occupancy_grid_core_assert.svh"

module voc_chk
    import voc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [STATUS_W-1:0]       m_status,
    input  logic                      m_found,
    input  logic [COUNT_W-1:0]        m_neighbour_count
);

    logic [STATUS_W+COUNT_W:0] m_payload;
    logic                      m_stall;
    logic                      s_take;
    logic                      m_counted;
    logic                      found_clean;
    logic                      count_clean;

    assign m_payload   = {m_status, m_found, m_neighbour_count};
    assign m_stall     = m_valid && !m_ready;
    assign s_take      = s_valid && s_ready;
    assign m_counted   = m_valid && (m_neighbour_count != '0);
    assign found_clean = (m_status == STATUS_OK) && (m_neighbour_count == '0);
    assign count_clean = (m_status == STATUS_OK) && !m_found
                      && (m_neighbour_count <= MAX_NEIGHBOURS);

    `VOG_CHECK(a_out_hold, m_stall |=> (m_valid && $stable(m_payload)), "result not held")
    `VOG_CHECK(a_one_at_a_time, s_take |=> !s_ready, "transaction taken while busy")
    `VOG_CHECK(a_found_ok, (m_valid && m_found) |-> found_clean, "found with bad status")
    `VOG_CHECK(a_count_range, m_counted |-> count_clean, "bad neighbour count")

endmodule

bind voxel_occupancy_grid_core voc_chk u_voc_chk (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_found           (m_found),
    .m_neighbour_count (m_neighbour_count)
);
